[src/assert_macros.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clk edge outside reset.
`define TFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a condition that must hold on every rising clk edge, also in reset.
`define TFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/tfd_pkg.sv]
// Types, constants and register codes of the tracked height fall detector.
package tfd_pkg;

  localparam int TRACKS_DEF = 32;
  localparam int HISTORY_DEPTH_DEF = 32;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_EOF    = 1'b1;

  localparam logic [2:0] REG_SENTINEL  = 3'd0;
  localparam logic [2:0] REG_RATIO     = 3'd1;
  localparam logic [2:0] REG_MIN_H     = 3'd2;
  localparam logic [2:0] REG_MAX_SPEED = 3'd3;
  localparam logic [2:0] REG_GAIN      = 3'd4;
  localparam logic [2:0] REG_REQUIRED  = 3'd5;
  localparam logic [2:0] REG_DISPLAY   = 3'd6;
  localparam logic [2:0] REG_COOLDOWN  = 3'd7;

  localparam logic signed [15:0] SENTINEL_RST  = 16'sh8000;
  localparam logic [7:0]         RATIO_RST     = 8'd128;
  localparam logic signed [15:0] MIN_H_RST     = 16'sd256;
  localparam logic signed [23:0] MAX_SPEED_RST = -24'sd256;
  localparam logic [16:0]        GAIN_RST      = 17'd74473;
  localparam logic [7:0]         REQUIRED_RST  = 8'd3;
  localparam logic [7:0]         DISPLAY_RST   = 8'd36;
  localparam logic [7:0]         COOLDOWN_RST  = 8'd36;

  typedef struct packed {
    logic signed [15:0] empty_height;
    logic [7:0]         fall_ratio;
    logic signed [15:0] min_height;
    logic signed [23:0] speed_limit;
    logic [16:0]        frame_gain;
    logic [7:0]         required_frames;
    logic [7:0]         show_frames;
    logic [7:0]         hold_frames;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_S_REC,
    ST_S_HIST,
    ST_S_EVAL,
    ST_E_OUT
  } state_t;

endpackage

[src/tfd_cfg.sv]
// APB register file holding the detector configuration.
module tfd_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output tfd_pkg::cfg_t     cfg
);
  import tfd_pkg::*;

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx = paddr[4:2];
  assign wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.empty_height    <= SENTINEL_RST;
      cfg.fall_ratio      <= RATIO_RST;
      cfg.min_height      <= MIN_H_RST;
      cfg.speed_limit     <= MAX_SPEED_RST;
      cfg.frame_gain      <= GAIN_RST;
      cfg.required_frames <= REQUIRED_RST;
      cfg.show_frames     <= DISPLAY_RST;
      cfg.hold_frames     <= COOLDOWN_RST;
    end else if (wr) begin
      unique case (idx)
        REG_SENTINEL:  cfg.empty_height    <= pwdata[15:0];
        REG_RATIO:     cfg.fall_ratio      <= pwdata[7:0];
        REG_MIN_H:     cfg.min_height      <= pwdata[15:0];
        REG_MAX_SPEED: cfg.speed_limit     <= pwdata[23:0];
        REG_GAIN:      cfg.frame_gain      <= pwdata[16:0];
        REG_REQUIRED:  cfg.required_frames <= pwdata[7:0];
        REG_DISPLAY:   cfg.show_frames     <= pwdata[7:0];
        REG_COOLDOWN:  cfg.hold_frames     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_SENTINEL:  prdata = {16'b0, cfg.empty_height};
      REG_RATIO:     prdata = {24'b0, cfg.fall_ratio};
      REG_MIN_H:     prdata = {16'b0, cfg.min_height};
      REG_MAX_SPEED: prdata = {8'b0, cfg.speed_limit};
      REG_GAIN:      prdata = {15'b0, cfg.frame_gain};
      REG_REQUIRED:  prdata = {24'b0, cfg.required_frames};
      REG_DISPLAY:   prdata = {24'b0, cfg.show_frames};
      REG_COOLDOWN:  prdata = {24'b0, cfg.hold_frames};
      default:       prdata = '0;
    endcase
  end

endmodule

[src/tfd_core.sv]
// Sequencer with track record memory and height history memory.
module tfd_core #(
  parameter int TRACKS        = tfd_pkg::TRACKS_DEF,
  parameter int HISTORY_DEPTH = tfd_pkg::HISTORY_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  tfd_pkg::cfg_t cfg,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [23:0]   s_tdata,
  input  logic          s_tuser,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [15:0]   m_tdata,
  output logic          m_tlast
);
  import tfd_pkg::*;

  localparam int TW = $clog2(TRACKS);
  localparam int IW = $clog2(HISTORY_DEPTH);
  localparam int AW = $clog2(TRACKS * HISTORY_DEPTH);
  localparam logic [IW-1:0] WP_LAST = IW'(HISTORY_DEPTH - 1);
  localparam logic [TW-1:0] T_LAST = TW'(TRACKS - 1);

  typedef struct packed {
    logic signed [15:0] last_h;
    logic signed [15:0] fill_s;
    logic [IW-1:0]      wp;
    logic               full;
    logic [7:0]         disp;
    logic [7:0]         cool;
    logic [7:0]         streak;
    logic               seen_last;
    logic               seen_this;
  } rec_t;

  rec_t               trk_mem [TRACKS];
  logic [TRACKS-1:0]  trk_vld;
  rec_t               trk_q;
  logic               trk_q_vld;
  logic signed [15:0] hist_mem [TRACKS*HISTORY_DEPTH];
  logic signed [15:0] hist_q;

  state_t             state, state_next;
  logic [TW-1:0]      tid;
  logic [TW-1:0]      cnt;
  logic signed [15:0] h_new;
  logic signed [15:0] h_old;
  rec_t               rec;
  logic [IW-1:0]      oi;
  logic               spd_ok;
  logic signed [34:0] prod_spd;
  logic signed [24:0] prod_thr;
  logic [4:0]         m_slot;
  logic [7:0]         m_cnt;

  rec_t               rst_rec, rec_rd, wdata, ev_rec, eof_rec;
  logic [TW-1:0]      trk_raddr, trk_waddr;
  logic               trk_we, hist_we, out_load;
  logic [AW-1:0]      hist_base, hist_raddr, hist_waddr;
  logic [IW-1:0]      oi_c;
  logic signed [15:0] h_old_c;
  logic signed [16:0] diff;
  logic signed [22:0] spd;
  logic signed [16:0] thr;
  logic               qual;
  logic [7:0]         st_inc;

  always_comb begin
    rst_rec = '0;
    rst_rec.last_h = SENTINEL_RST;
    rst_rec.fill_s = SENTINEL_RST;
    rec_rd = trk_q_vld ? trk_q : rst_rec;
    oi_c = (rec_rd.wp == WP_LAST) ? '0 : rec_rd.wp + 1'b1;
    hist_base = AW'(tid) * AW'(HISTORY_DEPTH);
    hist_raddr = hist_base + AW'(oi_c);
    hist_waddr = hist_base + AW'(rec.wp);
    h_old_c = (rec.full || (oi < rec.wp)) ? hist_q : rec.fill_s;
    diff = {h_new[15], h_new} - {rec.last_h[15], rec.last_h};
    spd = spd_ok ? prod_spd[34:12] : '0;
    thr = prod_thr[24:8];
    qual = (h_new < thr) && (h_old > cfg.min_height) && (spd < cfg.speed_limit);
    st_inc = (rec.streak != 8'hFF) ? rec.streak + 8'd1 : rec.streak;

    ev_rec = rec;
    ev_rec.last_h = h_new;
    ev_rec.wp = oi;
    ev_rec.full = rec.full || (rec.wp == WP_LAST);
    ev_rec.seen_this = 1'b1;
    if (rec.cool == 8'd0) begin
      if (qual) begin
        if (st_inc >= cfg.required_frames) begin
          ev_rec.disp = cfg.show_frames;
          ev_rec.cool = cfg.hold_frames;
          ev_rec.streak = 8'd0;
        end else begin
          ev_rec.streak = st_inc;
        end
      end else begin
        ev_rec.streak = 8'd0;
      end
    end

    eof_rec = rec_rd;
    if (rec_rd.seen_last && !rec_rd.seen_this) begin
      eof_rec.last_h = cfg.empty_height;
      eof_rec.fill_s = cfg.empty_height;
      eof_rec.wp = '0;
      eof_rec.full = 1'b0;
      eof_rec.streak = 8'd0;
    end
    eof_rec.seen_last = rec_rd.seen_this;
    eof_rec.seen_this = 1'b0;
    if (rec_rd.disp != 8'd0) eof_rec.disp = rec_rd.disp - 8'd1;
    if (rec_rd.cool != 8'd0) eof_rec.cool = rec_rd.cool - 8'd1;
  end

  always_comb begin
    state_next = state;
    s_tready = (state == ST_IDLE);
    trk_raddr = cnt;
    trk_waddr = (state == ST_E_OUT) ? cnt : tid;
    trk_we = 1'b0;
    hist_we = 1'b0;
    out_load = 1'b0;
    wdata = ev_rec;
    unique case (state)
      ST_IDLE: begin
        trk_raddr = s_tdata[TW-1:0];
        if (s_tvalid) begin
          if (s_tuser == OP_EOF) begin
            trk_raddr = '0;
            state_next = ST_E_OUT;
          end else if (32'(s_tdata[4:0]) < TRACKS) begin
            state_next = ST_S_REC;
          end
        end
      end
      ST_S_REC:  state_next = ST_S_HIST;
      ST_S_HIST: state_next = ST_S_EVAL;
      ST_S_EVAL: begin
        trk_we = 1'b1;
        hist_we = 1'b1;
        state_next = ST_IDLE;
      end
      ST_E_OUT: begin
        wdata = eof_rec;
        if (!m_tvalid || m_tready) begin
          out_load = 1'b1;
          trk_we = 1'b1;
          if (cnt == T_LAST) state_next = ST_IDLE;
          else trk_raddr = cnt + 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (trk_we) trk_mem[trk_waddr] <= wdata;
    trk_q <= trk_mem[trk_raddr];
    if (hist_we) hist_mem[hist_waddr] <= h_new;
    hist_q <= hist_mem[hist_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      trk_vld <= '0;
      trk_q_vld <= 1'b0;
      m_tvalid <= 1'b0;
      cnt <= '0;
    end else begin
      state <= state_next;
      trk_q_vld <= trk_vld[trk_raddr];
      if (trk_we) trk_vld[trk_waddr] <= 1'b1;
      if (state == ST_IDLE) cnt <= '0;
      else if (out_load) cnt <= cnt + 1'b1;
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      tid <= s_tdata[TW-1:0];
      h_new <= s_tdata[20:5];
    end
    if (state == ST_S_REC) begin
      rec <= rec_rd;
      oi <= oi_c;
    end
    if (state == ST_S_HIST) begin
      h_old <= h_old_c;
      prod_spd <= diff * $signed({1'b0, cfg.frame_gain});
      prod_thr <= $signed({1'b0, cfg.fall_ratio}) * h_old_c;
      spd_ok <= (rec.last_h != cfg.empty_height) && (h_new != cfg.empty_height);
    end
    if (out_load) begin
      m_slot <= 5'(cnt);
      m_cnt <= rec_rd.disp;
      m_tlast <= (cnt == T_LAST);
    end
  end

  assign m_tdata = {3'b0, m_cnt, m_slot};

endmodule

[src/tracked_height_fall_detector.sv]
// Top level of the tracked height fall detector.
// A height sample passes in order through track record read, history read,
// multiply and write-back, as the history read needs the track record read
// first; a sample whose track is at or above TRACKS is dropped. An
// end-of-frame item sweeps the track record memory one track per cycle while
// the output is not stalled and gives TRACKS results. Track records reset
// through per-track valid bits and history slots through a per-track fill
// mark, so there is no clearing pass after reset.
`include "assert_macros.svh"

module tracked_height_fall_detector #(
  parameter int TRACKS        = tfd_pkg::TRACKS_DEF,
  parameter int HISTORY_DEPTH = tfd_pkg::HISTORY_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // track_id[4:0], height[20:5], zero fill
  input  logic        s_tuser,   // operation[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // slot[4:0], fall_countdown[12:5], zero fill
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tfd_pkg::*;

  cfg_t cfg;

  tfd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tfd_core #(
    .TRACKS        (TRACKS),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  `TFD_ASSERT(a_last_slot, m_tvalid && m_tlast |-> 32'(m_tdata[4:0]) == TRACKS - 1, "tlast off")
  `TFD_ASSERT(a_eof_busy, s_tvalid && s_tready && s_tuser |=> !s_tready, "taken in sweep")
  `TFD_ASSERT(a_pad_zero, m_tvalid |-> m_tdata[15:13] == 3'b0, "output padding not zero")
  `TFD_ASSERT_ALWAYS(a_pready, pready, "pready low")

endmodule

[tb/tracked_height_fall_detector_tb.sv]
// Testbench for the tracked height fall detector: random and directed items, scoreboard.
`timescale 1ns / 1ps

class fall_scoreboard;
  localparam int NT = 32;
  localparam int ND = 32;
  logic signed [15:0] sentinel;
  logic [7:0] ratio;
  logic signed [15:0] min_h;
  logic signed [23:0] max_speed;
  logic [16:0] gain;
  logic [7:0] required;
  logic [7:0] display;
  logic [7:0] cooldown;
  logic signed [15:0] hist [NT][ND];
  logic signed [15:0] prev_h [NT];
  int wr_idx [NT];
  int disp_cnt [NT];
  int cool_cnt [NT];
  int streak [NT];
  bit seen_last [NT];
  bit seen_now [NT];
  logic [13:0] countdowns [$];
  int errors;

  function new();
    sentinel = tfd_pkg::SENTINEL_RST;
    ratio = tfd_pkg::RATIO_RST;
    min_h = tfd_pkg::MIN_H_RST;
    max_speed = tfd_pkg::MAX_SPEED_RST;
    gain = tfd_pkg::GAIN_RST;
    required = tfd_pkg::REQUIRED_RST;
    display = tfd_pkg::DISPLAY_RST;
    cooldown = tfd_pkg::COOLDOWN_RST;
    errors = 0;
    for (int t = 0; t < NT; t++) begin
      clear_track(t);
      disp_cnt[t] = 0;
      cool_cnt[t] = 0;
      seen_last[t] = 0;
      seen_now[t] = 0;
    end
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      tfd_pkg::REG_SENTINEL: sentinel = v[15:0];
      tfd_pkg::REG_RATIO: ratio = v[7:0];
      tfd_pkg::REG_MIN_H: min_h = v[15:0];
      tfd_pkg::REG_MAX_SPEED: max_speed = v[23:0];
      tfd_pkg::REG_GAIN: gain = v[16:0];
      tfd_pkg::REG_REQUIRED: required = v[7:0];
      tfd_pkg::REG_DISPLAY: display = v[7:0];
      default: cooldown = v[7:0];
    endcase
  endfunction

  function void clear_track(int t);
    for (int h = 0; h < ND; h++) hist[t][h] = sentinel;
    prev_h[t] = sentinel;
    wr_idx[t] = 0;
    streak[t] = 0;
  endfunction

  function longint floor_div(longint p, longint d);
    if (p >= 0) return p / d;
    return -((-p + d - 1) / d);
  endfunction

  function void note_item(logic op, logic [4:0] tid, logic signed [15:0] h);
    longint old_h, speed, thr;
    int oi;
    if (op == tfd_pkg::OP_SAMPLE) begin
      oi = (wr_idx[tid] + 1) % ND;
      old_h = hist[tid][oi];
      speed = 0;
      if (prev_h[tid] != sentinel && h != sentinel) begin
        speed = floor_div((longint'(h) - longint'(prev_h[tid])) * longint'(gain), 4096);
        if (speed > 8388607) speed = 8388607;
        if (speed < -8388608) speed = -8388608;
      end
      hist[tid][wr_idx[tid]] = h;
      prev_h[tid] = h;
      wr_idx[tid] = oi;
      seen_now[tid] = 1;
      if (cool_cnt[tid] > 0) return;
      thr = floor_div(longint'(ratio) * old_h, 256);
      if (h < thr && old_h > min_h && speed < max_speed) begin
        if (streak[tid] < 255) streak[tid]++;
        if (streak[tid] >= required) begin
          disp_cnt[tid] = display;
          cool_cnt[tid] = cooldown;
          streak[tid] = 0;
        end
      end else begin
        streak[tid] = 0;
      end
    end else begin
      for (int t = 0; t < NT; t++) begin
        if (seen_last[t] && !seen_now[t]) clear_track(t);
        seen_last[t] = seen_now[t];
        seen_now[t] = 0;
      end
      for (int t = 0; t < NT; t++) begin
        countdowns.push_back({t == NT - 1, disp_cnt[t][7:0], t[4:0]});
        if (disp_cnt[t] > 0) disp_cnt[t]--;
        if (cool_cnt[t] > 0) cool_cnt[t]--;
      end
    end
  endfunction

  function void check_result(logic [15:0] data, logic last);
    logic [13:0] exp_v;
    if (countdowns.size() == 0) begin
      $display("%0t: unexpected result data=%h last=%b", $time, data, last);
      errors++;
      return;
    end
    exp_v = countdowns.pop_front();
    if (data[4:0] !== exp_v[4:0] || data[12:5] !== exp_v[12:5] || last !== exp_v[13]
        || data[15:13] !== 3'b0) begin
      $display("%0t: mismatch expected slot=%0d count=%0d last=%b, %s",
               $time, exp_v[4:0], exp_v[12:5], exp_v[13],
               $sformatf("got slot=%0d count=%0d last=%b", data[4:0], data[12:5], last));
      errors++;
    end
  endfunction
endclass

module tracked_height_fall_detector_tb;
  import tfd_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [23:0] s_tdata = '0;   // track_id[4:0], height[20:5], zero fill
  logic s_tuser = 0;           // operation[0]
  logic m_tvalid;
  logic m_tready = 0;
  logic [15:0] m_tdata;        // slot[4:0], fall_countdown[12:5], zero fill
  logic m_tlast;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  fall_scoreboard board;
  int idle_pct = 24;
  int hold_off = 0;
  int quiet = 0;

  tracked_height_fall_detector dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata, m_tlast);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 0;
    end else begin
      m_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    board.set_reg(idx, v);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic send_item(logic op, logic [4:0] tid, logic signed [15:0] h);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1; s_tuser <= op; s_tdata <= {3'b0, h, tid};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_item(op, tid, h);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (board.countdowns.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic fall_run(logic [4:0] tid, int steps);
    int h0 = $urandom_range(30000, 400);
    for (int i = 0; i < steps; i++) begin
      if ($urandom_range(9) == 0) send_item(OP_SAMPLE, 5'($urandom), 16'($urandom));
      send_item(OP_SAMPLE, tid, 16'((i < steps / 2) ? h0 : h0 / 8 - $urandom_range(50)));
      if ($urandom_range(3) == 0) send_item(OP_EOF, 0, 0);
    end
  endtask

  initial begin
    board = new();
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: field extremes, both operations, cooldown, sentinel change
    send_item(OP_SAMPLE, 0, 16'sh7fff);
    send_item(OP_SAMPLE, 31, 16'sh8000);
    send_item(OP_SAMPLE, 31, 16'sh7fff);
    send_item(OP_SAMPLE, 31, 16'sh8000);
    send_item(OP_SAMPLE, 5, 16'sh0000);
    send_item(OP_SAMPLE, 5, -16'sd1);
    send_item(OP_EOF, 31, 16'shffff);
    send_item(OP_EOF, 0, 0);
    drain();
    write_reg(REG_REQUIRED, 0);
    write_reg(REG_DISPLAY, 255);
    write_reg(REG_COOLDOWN, 2);
    write_reg(REG_SENTINEL, 0);
    for (int i = 0; i < 35; i++) send_item(OP_SAMPLE, 7, (i < 33) ? 16'sd20000 : 16'sd100);
    send_item(OP_SAMPLE, 7, 16'sd50);
    send_item(OP_EOF, 0, 0);
    send_item(OP_SAMPLE, 7, 16'sd10);
    send_item(OP_EOF, 0, 0);
    send_item(OP_EOF, 0, 0);
    drain();
    // random phases with varied settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_SENTINEL, (ph == 5) ? 32'h7fff : $urandom);
      write_reg(REG_RATIO, (ph == 1) ? 255 : (ph == 2) ? 0 : $urandom);
      write_reg(REG_MIN_H, (ph == 3) ? 32'h8000 : (ph == 4) ? 32'h7fff : $urandom_range(500));
      write_reg(REG_MAX_SPEED, (ph == 1) ? 32'h7fffff : (ph == 2) ? 32'h800000 : $urandom);
      write_reg(REG_GAIN, (ph == 1) ? 131071 : (ph == 2) ? 0 : $urandom_range(131071));
      write_reg(REG_REQUIRED, (ph == 3) ? 255 : $urandom_range(4, 1));
      write_reg(REG_DISPLAY, (ph == 2) ? 0 : $urandom);
      write_reg(REG_COOLDOWN, (ph == 4) ? 255 : (ph == 2) ? 0 : $urandom_range(6));
      idle_pct = (ph == 2) ? 0 : 24;
      if (ph == 3) hold_off = 400;
      for (int n = 0; n < 9; n++) begin
        if ($urandom_range(3) != 0) fall_run(5'($urandom_range(31)), $urandom_range(12, 3));
        else send_item(1'($urandom), 5'($urandom), 16'($urandom));
      end
      drain();
    end
    idle_pct = 24;
    drain();
    if (board.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
